// File: rtl/core/lslc_pkg.sv
// Package for the per-link sequence loss checker.
// Holds the payload structs, status and register codes and table sizes.
// No dependencies.
`timescale 1ns / 1ps

package lslc_pkg;

    // Table and frame limits.
    localparam int LINK_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(LINK_TABLE_DEPTH);
    localparam int MIN_FRAME_BYTES  = 20;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINK  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [15:0] FIRST_LINK_RESET = 16'd0;
    localparam logic [15:0] LAST_LINK_RESET  = 16'd1023;

    // Payload verdict codes.
    localparam logic [1:0] VD_MATCH    = 2'd1;
    localparam logic [1:0] VD_MISMATCH = 2'd2;

    typedef enum logic [2:0] {
        ST_IN_ORDER     = 3'd0,
        ST_GAP          = 3'd1,
        ST_DUPLICATE    = 3'd2,
        ST_TOO_SHORT    = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } t_status;

    // One received frame summary.
    typedef struct packed {
        logic [13:0] frame_length;
        logic [15:0] link_id;
        logic [63:0] sequence_req;
        logic [1:0]  payload_verdict;
    } t_in;

    // One result.
    typedef struct packed {
        t_status     status;
        logic [63:0] gap_size;
        logic [63:0] packets_seen;
        logic [63:0] bytes_seen;
        logic [63:0] good_count;
        logic [63:0] bad_count;
        logic [63:0] lost_count;
        logic [63:0] duplicate_count;
    } t_out;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic             drop;
        t_status          status;
        logic [IDX_W-1:0] idx;
        logic [63:0]      seq;
        logic [13:0]      len;
        logic [1:0]       verdict;
    } t_job;

    // One row of the per-link table.
    typedef struct packed {
        logic [63:0] expected;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [63:0] matched;
        logic [63:0] mismatches;
        logic [63:0] losses;
        logic [63:0] repeats;
    } t_entry;

endpackage

// File: rtl/core/lslc_front.sv
// Front part of the checker: configuration registers and request classification.
// Depends on lslc_pkg.
`timescale 1ns / 1ps

module lslc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lslc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lslc_pkg::t_in                     i_in_data,
    input  logic                              i_q_full,
    input  logic                              i_clearing,
    output logic                              o_push,
    output lslc_pkg::t_job                    o_job
);

    logic [15:0] r_first_link;
    logic [15:0] r_last_link;
    logic [16:0] w_offset;
    logic        w_short;
    logic        w_outside;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_link <= lslc_pkg::FIRST_LINK_RESET;
            r_last_link  <= lslc_pkg::LAST_LINK_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lslc_pkg::CFG_FIRST_LINK) begin
                r_first_link <= i_cfg_data;
            end else if (i_cfg_index == lslc_pkg::CFG_LAST_LINK) begin
                r_last_link <= i_cfg_data;
            end
        end
    end

    // A request enters when the queue has room and the table is not being cleared.
    assign o_in_ready = !i_q_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    // A link below the window borrows, which makes the offset exceed the depth.
    assign w_offset  = {1'b0, i_in_data.link_id} - {1'b0, r_first_link};
    assign w_short   = i_in_data.frame_length < 14'(lslc_pkg::MIN_FRAME_BYTES);
    assign w_outside = (w_offset >= 17'(lslc_pkg::LINK_TABLE_DEPTH)) ||
                       (i_in_data.link_id > r_last_link);

    always_comb begin
        o_job.drop    = w_short || w_outside;
        o_job.status  = w_short ? lslc_pkg::ST_TOO_SHORT : lslc_pkg::ST_OUT_OF_RANGE;
        o_job.idx     = w_offset[lslc_pkg::IDX_W-1:0];
        o_job.seq     = i_in_data.sequence_req;
        o_job.len     = i_in_data.frame_length;
        o_job.verdict = i_in_data.payload_verdict;
    end

endmodule

// File: rtl/core/lslc_queue.sv
// Short request queue between the front and the back of the checker.
// Depends on lslc_pkg.
`timescale 1ns / 1ps

module lslc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lslc_pkg::t_job  i_data,
    output logic            o_full,
    output logic            o_valid,
    output lslc_pkg::t_job  o_data,
    input  logic            i_pop
);

    lslc_pkg::t_job                  r_slot [lslc_pkg::QUEUE_DEPTH];
    logic [lslc_pkg::QPTR_W-1:0]     r_wp;
    logic [lslc_pkg::QPTR_W-1:0]     r_rp;
    logic [lslc_pkg::QCNT_W-1:0]     r_cnt;
    logic                            w_do_push;
    logic                            w_do_pop;

    function automatic logic [lslc_pkg::QPTR_W-1:0] next_ptr(
        input logic [lslc_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == lslc_pkg::QPTR_W'(lslc_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign o_full    = r_cnt == lslc_pkg::QCNT_W'(lslc_pkg::QUEUE_DEPTH);
    assign o_valid   = r_cnt != '0;
    assign o_data    = r_slot[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= next_ptr(r_wp);
            end
            if (w_do_pop) begin
                r_rp <= next_ptr(r_rp);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/core/lslc_back.sv
// Back part of the checker: per-link table, read-modify-write sequencer and result register.
// Depends on lslc_pkg.
`timescale 1ns / 1ps

module lslc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  lslc_pkg::t_job  i_q_job,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lslc_pkg::t_out  o_out_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    lslc_pkg::t_entry              r_mem [lslc_pkg::LINK_TABLE_DEPTH];
    lslc_pkg::t_entry              r_rd;

    t_state                        r_state, n_state;
    logic [lslc_pkg::IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic                          r_out_valid, n_out_valid;
    lslc_pkg::t_out                r_out_data, n_out_data;
    lslc_pkg::t_job                r_job, n_job;
    logic [64:0]                   r_diff, n_diff;
    logic                          r_eq, n_eq;

    logic                          w_out_free;
    logic                          w_re;
    logic                          w_we;
    logic [lslc_pkg::IDX_W-1:0]    w_waddr;
    lslc_pkg::t_entry              w_wdata;
    lslc_pkg::t_entry              w_upd;
    logic                          w_dup;
    logic                          w_gap;
    logic [63:0]                   w_gap_size;
    lslc_pkg::t_status             w_status;

    assign o_clearing  = r_state == S_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Classify against the expected number and form the updated row.
    always_comb begin
        w_dup      = !r_eq && r_diff[64];
        w_gap      = !r_eq && !r_diff[64];
        w_gap_size = w_gap ? r_diff[63:0] : 64'd0;
        if (r_eq) begin
            w_status = lslc_pkg::ST_IN_ORDER;
        end else if (w_gap) begin
            w_status = lslc_pkg::ST_GAP;
        end else begin
            w_status = lslc_pkg::ST_DUPLICATE;
        end
        w_upd.expected   = w_dup ? r_rd.expected : r_job.seq + 64'd1;
        w_upd.packets    = r_rd.packets + 64'd1;
        w_upd.bytes      = r_rd.bytes + {50'd0, r_job.len};
        w_upd.matched    = r_rd.matched +
                           {63'd0, r_job.verdict == lslc_pkg::VD_MATCH};
        w_upd.mismatches = r_rd.mismatches +
                           {63'd0, r_job.verdict == lslc_pkg::VD_MISMATCH};
        w_upd.losses     = r_rd.losses + w_gap_size;
        w_upd.repeats    = r_rd.repeats + {63'd0, w_dup};
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_job       = r_job;
        n_diff      = r_diff;
        n_eq        = r_eq;
        o_pop       = 1'b0;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_job.idx;
        w_wdata     = w_upd;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_idx;
                w_wdata   = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == lslc_pkg::IDX_W'(lslc_pkg::LINK_TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_job.drop) begin
                        // Dropped frames answer at once and leave the table alone.
                        if (w_out_free) begin
                            o_pop             = 1'b1;
                            n_out_valid       = 1'b1;
                            n_out_data        = '0;
                            n_out_data.status = i_q_job.status;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        w_re    = 1'b1;
                        n_job   = i_q_job;
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                n_diff  = {1'b0, r_job.seq} - {1'b0, r_rd.expected};
                n_eq    = r_job.seq == r_rd.expected;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    w_we                       = 1'b1;
                    n_out_valid                = 1'b1;
                    n_out_data.status          = w_status;
                    n_out_data.gap_size        = w_gap_size;
                    n_out_data.packets_seen    = w_upd.packets;
                    n_out_data.bytes_seen      = w_upd.bytes;
                    n_out_data.good_count      = w_upd.matched;
                    n_out_data.bad_count       = w_upd.mismatches;
                    n_out_data.lost_count      = w_upd.losses;
                    n_out_data.duplicate_count = w_upd.repeats;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_job      <= n_job;
        r_diff     <= n_diff;
        r_eq       <= n_eq;
    end

    // Per-link table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[i_q_job.idx];
        end
    end

endmodule

// File: rtl/core/per_link_sequence_loss_checker.sv
// Per-link sequence loss checker, top level.
// A tracked frame passes the queue, then the table read, compare and write-back states;
// the write-back also loads the result register. A dropped frame is answered from the queue.
// The back part starts the next tracked frame only after the last one's write-back.
// Reset is synchronous, active low; afterwards a clearing pass zeroes all 1024 table
// entries, and no frame is taken until it ends. Configuration writes are taken at any time.
// Depends on lslc_pkg, lslc_front, lslc_queue and lslc_back.
`timescale 1ns / 1ps

module per_link_sequence_loss_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lslc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lslc_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lslc_pkg::t_out                  o_out_data
);

    logic           w_push;
    lslc_pkg::t_job w_push_job;
    logic           w_q_full;
    logic           w_q_valid;
    lslc_pkg::t_job w_q_job;
    logic           w_pop;
    logic           w_clearing;

    // Accept and classify requests.
    lslc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // Decouple the front from the table sequencer.
    lslc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_job),
        .i_pop   (w_pop)
    );

    // Update the per-link table and present results.
    lslc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: dv/per_link_sequence_loss_checker_tb.sv
// Self-checking testbench for the per-link sequence loss checker.
// Keeps its own copy of the per-link table and checks every result field by field.
// Depends on lslc_pkg and per_link_sequence_loss_checker.
`timescale 1ns / 1ps

module per_link_sequence_loss_checker_tb;

    import lslc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_LINK;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;

    // Frames waiting to be sent and results still owed by the block.
    t_in  frame_q[$];
    t_out outcome_q[$];

    // Predicted per-link table and window, indexed by link minus first link.
    logic [63:0] tbl_next_seq [LINK_TABLE_DEPTH];
    logic [63:0] tbl_packets  [LINK_TABLE_DEPTH];
    logic [63:0] tbl_bytes    [LINK_TABLE_DEPTH];
    logic [63:0] tbl_good     [LINK_TABLE_DEPTH];
    logic [63:0] tbl_bad      [LINK_TABLE_DEPTH];
    logic [63:0] tbl_lost     [LINK_TABLE_DEPTH];
    logic [63:0] tbl_repeats  [LINK_TABLE_DEPTH];
    logic [15:0] win_first = FIRST_LINK_RESET;
    logic [15:0] win_last  = LAST_LINK_RESET;

    // Next in-order number per entry as seen by the frame generator.
    logic [63:0] gen_next_seq [LINK_TABLE_DEPTH];

    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;
    int fail_count = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int windows_set = 0;
    int status_seen [8];

    per_link_sequence_loss_checker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // True when the link falls inside the current window and the table depth.
    function automatic bit in_window(input logic [15:0] link);
        return link >= win_first && link <= win_last &&
               (int'(link) - int'(win_first)) < LINK_TABLE_DEPTH;
    endfunction

    // Updates the predicted table with one accepted frame and returns its result.
    function automatic t_out account_frame(input t_in f);
        t_out        r;
        int          idx;
        logic [63:0] want_seq;
        r = '0;
        if (f.frame_length < MIN_FRAME_BYTES) begin
            r.status = ST_TOO_SHORT;
        end else if (!in_window(f.link_id)) begin
            r.status = ST_OUT_OF_RANGE;
        end else begin
            idx = int'(f.link_id) - int'(win_first);
            if (f.payload_verdict == VD_MATCH) begin
                tbl_good[idx] = tbl_good[idx] + 64'd1;
            end else if (f.payload_verdict == VD_MISMATCH) begin
                tbl_bad[idx] = tbl_bad[idx] + 64'd1;
            end
            want_seq = tbl_next_seq[idx];
            if (f.sequence_req == want_seq) begin
                r.status = ST_IN_ORDER;
                tbl_next_seq[idx] = f.sequence_req + 64'd1;
            end else if (f.sequence_req > want_seq) begin
                r.status   = ST_GAP;
                r.gap_size = f.sequence_req - want_seq;
                tbl_lost[idx] = tbl_lost[idx] + r.gap_size;
                tbl_next_seq[idx] = f.sequence_req + 64'd1;
            end else begin
                r.status = ST_DUPLICATE;
                tbl_repeats[idx] = tbl_repeats[idx] + 64'd1;
            end
            tbl_packets[idx] = tbl_packets[idx] + 64'd1;
            tbl_bytes[idx]   = tbl_bytes[idx] + 64'(f.frame_length);
            r.packets_seen    = tbl_packets[idx];
            r.bytes_seen      = tbl_bytes[idx];
            r.good_count      = tbl_good[idx];
            r.bad_count       = tbl_bad[idx];
            r.lost_count      = tbl_lost[idx];
            r.duplicate_count = tbl_repeats[idx];
        end
        return r;
    endfunction

    // Draws the idle cycles before the next request, with occasional stretches of none.
    function automatic int pick_pause(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Request driver: holds each frame until taken, then waits a random gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                outcome_q.push_back(account_frame(in_data));
                frames_sent++;
                send_wait = pick_pause(send_calm);
            end
            if (in_valid && !in_ready) begin
                // Still waiting for the block to take the current request.
            end else if (send_wait > 0) begin
                send_wait--;
                in_valid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                in_data  <= frame_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each result with the oldest prediction, stalls at random.
    always @(posedge clk) begin
        t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && out_valid) begin
                if (outcome_q.size() == 0) begin
                    $error("result arrived with no frame outstanding");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(want.status), 64'(out_data.status));
                    check_field("gap_size", want.gap_size, out_data.gap_size);
                    check_field("packets_seen", want.packets_seen, out_data.packets_seen);
                    check_field("bytes_seen", want.bytes_seen, out_data.bytes_seen);
                    check_field("good_count", want.good_count, out_data.good_count);
                    check_field("bad_count", want.bad_count, out_data.bad_count);
                    check_field("lost_count", want.lost_count, out_data.lost_count);
                    check_field("duplicate_count", want.duplicate_count,
                                out_data.duplicate_count);
                    status_seen[want.status]++;
                    results_checked++;
                end
                recv_wait = pick_pause(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Queues one frame and tracks the number that keeps its link in order.
    task automatic send_frame(input logic [13:0] len, input logic [15:0] link,
                              input logic [63:0] seq, input logic [1:0] verdict);
        t_in f;
        int  idx;
        f.frame_length    = len;
        f.link_id         = link;
        f.sequence_req    = seq;
        f.payload_verdict = verdict;
        if (len >= MIN_FRAME_BYTES && in_window(link)) begin
            idx = int'(link) - int'(win_first);
            if (seq >= gen_next_seq[idx]) begin
                gen_next_seq[idx] = seq + 64'd1;
            end
        end
        frame_q.push_back(f);
    endtask

    // Waits until every frame is sent and answered, then lets the pipeline settle.
    task automatic wait_idle();
        while (frame_q.size() > 0 || in_valid || outcome_q.size() > 0) begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Writes both window registers; called at a clock edge while the block is idle.
    task automatic set_window(input logic [15:0] first, input logic [15:0] last);
        cfg_index <= CFG_FIRST_LINK;
        cfg_data  <= first;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        win_first = first;
        cfg_index <= CFG_LAST_LINK;
        cfg_data  <= last;
        do @(posedge clk); while (!cfg_ready);
        win_last = last;
        cfg_valid <= 1'b0;
        windows_set++;
    endtask

    // Random frames: mostly in-order runs on a few hot links, plus gaps, repeats and noise.
    task automatic random_phase(input int count);
        int          pick;
        int          span;
        int          idx;
        bit          open;
        logic [15:0] link;
        logic [63:0] seq;
        logic [63:0] base;
        logic [13:0] len;
        open = win_first <= win_last;
        span = 0;
        if (open) begin
            span = int'(win_last) - int'(win_first);
            if (span > LINK_TABLE_DEPTH - 1) begin
                span = LINK_TABLE_DEPTH - 1;
            end
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, (span < 7) ? span : 7)
                                               : $urandom_range(0, span);
            link = open ? 16'(int'(win_first) + idx) : 16'($urandom);
            base = gen_next_seq[idx];
            if (pick < 60) begin
                seq = base;
            end else if (pick < 72) begin
                seq = base + $urandom_range(1, 6);
            end else if (pick < 86 && pick >= 76) begin
                seq = base - $urandom_range(1, 4);
            end else begin
                seq = {$urandom, $urandom};
            end
            if (pick >= 86 && pick < 93) begin
                len = 14'($urandom_range(0, MIN_FRAME_BYTES - 1));
            end else if ($urandom_range(0, 15) == 0) begin
                len = 14'($urandom);
            end else begin
                len = 14'($urandom_range(MIN_FRAME_BYTES, 1518));
            end
            if (pick >= 93) begin
                link = 16'($urandom);
            end
            send_frame(len, link, seq, 2'($urandom));
            while (frame_q.size() > 4) begin
                @(posedge clk);
            end
        end
    endtask

    // Main sequence: reset, directed frames under several windows, then random phases.
    initial begin
        logic [15:0] rand_first;
        int          rand_last;
        for (int i = 0; i < LINK_TABLE_DEPTH; i++) begin
            tbl_next_seq[i] = '0;
            tbl_packets[i]  = '0;
            tbl_bytes[i]    = '0;
            tbl_good[i]     = '0;
            tbl_bad[i]      = '0;
            tbl_lost[i]     = '0;
            tbl_repeats[i]  = '0;
            gen_next_seq[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            status_seen[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset window: in order, gap, duplicate, unused verdict, short frames,
        // number wrap with the lost counter wrapping, and links past the table.
        send_frame(14'(MIN_FRAME_BYTES), 16'd0, 64'd0, VD_MATCH);
        send_frame(14'h3FFF, 16'd0, 64'd1, VD_MISMATCH);
        send_frame(14'd64, 16'd0, 64'd5, 2'd0);
        send_frame(14'd64, 16'd0, 64'd2, 2'd3);
        send_frame(14'd64, 16'd0, 64'd6, VD_MATCH);
        send_frame(14'(MIN_FRAME_BYTES - 1), 16'd0, 64'd7, VD_MATCH);
        send_frame(14'd0, 16'hFFFF, 64'd0, 2'd0);
        send_frame(14'd100, 16'd1023, '1, VD_MATCH);
        send_frame(14'd100, 16'd1023, 64'd0, 2'd0);
        send_frame(14'd100, 16'd1023, 64'd0, VD_MISMATCH);
        send_frame(14'd100, 16'd1023, 64'h8000_0000_0000_0000, 2'd0);
        send_frame(14'd100, 16'd1024, 64'd0, VD_MATCH);
        send_frame(14'd100, 16'hFFFF, '1, VD_MATCH);
        wait_idle();

        // Single top link maps onto entry zero.
        set_window(16'hFFFF, 16'hFFFF);
        send_frame(14'(MIN_FRAME_BYTES), 16'hFFFF, 64'd0, VD_MISMATCH);
        send_frame(14'(MIN_FRAME_BYTES), 16'hFFFE, 64'd0, VD_MATCH);
        wait_idle();

        // Empty window rejects every link.
        set_window(16'd100, 16'd50);
        send_frame(14'd200, 16'd75, 64'd1, VD_MATCH);
        send_frame(14'd200, 16'd100, 64'd1, VD_MATCH);
        wait_idle();

        // Window wider than the table is cut at the table depth.
        set_window(16'd1000, 16'hFFFF);
        send_frame(14'd80, 16'd1000, 64'd9, VD_MATCH);
        send_frame(14'd80, 16'd2023, 64'd3, VD_MISMATCH);
        send_frame(14'd80, 16'd2024, 64'd3, VD_MATCH);
        wait_idle();

        set_window(16'd0, 16'd0);
        send_frame(14'd80, 16'd0, 64'd8, 2'd3);
        send_frame(14'd80, 16'd1, 64'd8, VD_MATCH);
        wait_idle();

        // Random traffic under a range of windows.
        set_window(16'd0, 16'd1023);
        random_phase(300);
        wait_idle();
        set_window(16'd64512, 16'hFFFF);
        random_phase(250);
        wait_idle();
        set_window(16'd30000, 16'd30003);
        random_phase(250);
        wait_idle();
        set_window(16'd0, 16'hFFFF);
        random_phase(200);
        wait_idle();
        rand_first = 16'($urandom);
        rand_last  = int'(rand_first) + $urandom_range(0, 1200);
        set_window(rand_first, (rand_last > 65535) ? 16'hFFFF : 16'(rand_last));
        random_phase(200);
        wait_idle();
        set_window(16'd9, 16'd8);
        random_phase(50);
        wait_idle();
        set_window(FIRST_LINK_RESET, LAST_LINK_RESET);
        random_phase(50);
        wait_idle();

        $display("Sent %0d frames under %0d window settings, checked %0d results.",
                 frames_sent, windows_set, results_checked);
        $display("Outcomes: in order %0d, gap %0d, duplicate %0d, short %0d, outside %0d.",
                 status_seen[ST_IN_ORDER], status_seen[ST_GAP], status_seen[ST_DUPLICATE],
                 status_seen[ST_TOO_SHORT], status_seen[ST_OUT_OF_RANGE]);
        if (fail_count == 0) begin
            $display("** per_link_sequence_loss_checker: PASSED **");
        end else begin
            $display("** per_link_sequence_loss_checker: FAILED **");
        end
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial begin
        #1_000_000;
        $display("Timeout with %0d results outstanding.", outcome_q.size());
        $display("** per_link_sequence_loss_checker: FAILED **");
        $finish;
    end

endmodule

// File: per_link_sequence_loss_checker.f
rtl/core/lslc_pkg.sv
rtl/core/lslc_front.sv
rtl/core/lslc_queue.sv
rtl/core/lslc_back.sv
rtl/core/per_link_sequence_loss_checker.sv
dv/per_link_sequence_loss_checker_tb.sv
